FILE: src/rigid_body_quaternion_euler_step_defines.svh
// Assertion macros shared by the rigid body step design.
`ifndef RIGID_BODY_QUATERNION_EULER_STEP_DEFINES_SVH
`define RIGID_BODY_QUATERNION_EULER_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define RB_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define RB_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define RB_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)
`define RB_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

FILE: src/rbqe_pkg.sv
// ----------------------------------------------------------------------------
// rbqe_pkg
// Types, constants and the micro-program of the rigid body step.
// ----------------------------------------------------------------------------
package rbqe_pkg;
	localparam int FRAC_BITS = 16;
	localparam logic signed [33:0] DT_Q32  = 34'sd4294967;
	localparam logic signed [33:0] DTH_Q32 = 34'sd2147484;
	localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
	localparam logic [67:0] GRAV_Q32 = 68'd42133629174;
	localparam logic [67:0] GRAV_R =
		(GRAV_Q32 + (68'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic signed [31:0] GRAV_Q =
		(GRAV_R > 68'd2147483647) ? 32'sh7fffffff : GRAV_R[31:0];

	// Configuration register indexes.
	localparam logic [2:0] REG_INV_JX     = 3'd0;
	localparam logic [2:0] REG_INV_JY     = 3'd1;
	localparam logic [2:0] REG_INV_JZ     = 3'd2;
	localparam logic [2:0] REG_DIFF_YZ    = 3'd3;
	localparam logic [2:0] REG_DIFF_ZX    = 3'd4;
	localparam logic [2:0] REG_INV_MASS   = 3'd5;
	localparam logic [2:0] REG_MAX_TORQUE = 3'd6;
	localparam logic [2:0] REG_MAX_THRUST = 3'd7;

	// Register file slots (32 words).
	typedef enum logic [4:0] {
		R_QW, R_QX, R_QY, R_QZ, R_WX, R_WY, R_WZ, R_PN, R_PE, R_PD,
		R_VN, R_VE, R_VD, R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6,
		R_T7, R_T8, R_T9, R_TA, R_TB, R_TC, R_TH, R_TX, R_TY, R_TZ,
		R_ZERO, R_GR
	} reg_t;

	// Operand B source selects.
	typedef enum logic [3:0] {
		B_REG, B_IJX, B_IJY, B_IJZ, B_DYZ, B_DZX, B_DXY, B_IM, B_DT, B_DTH
	} bsel_t;

	// Operations of the shared unit.
	typedef enum logic [2:0] {
		OP_QMUL, OP_KMUL, OP_ADD, OP_SUB, OP_NEG, OP_DBL
	} op_t;

	typedef struct packed {
		op_t   op;
		reg_t  ra;
		reg_t  rb;
		bsel_t bs;
		reg_t  rd;
	} uop_t;

	localparam int NUOP = 78;
	localparam int PCW  = 7;

	function automatic uop_t u(op_t o, reg_t a, reg_t b, bsel_t s, reg_t d);
		uop_t x;
		x.op = o; x.ra = a; x.rb = b; x.bs = s; x.rd = d;
		return x;
	endfunction

	function automatic uop_t prog(logic [PCW-1:0] pc);
		uop_t r;
		r = u(OP_ADD, R_ZERO, R_ZERO, B_REG, R_ZERO);
		case (pc)
			// gyroscopic terms and torque sums
			7'd0:  r = u(OP_QMUL, R_WY, R_WZ, B_REG, R_T0);
			7'd1:  r = u(OP_QMUL, R_T0, R_ZERO, B_DYZ, R_T0);
			7'd2:  r = u(OP_ADD, R_T0, R_TX, B_REG, R_T0);
			7'd3:  r = u(OP_QMUL, R_T0, R_ZERO, B_IJX, R_T0);
			7'd4:  r = u(OP_QMUL, R_WZ, R_WX, B_REG, R_T1);
			7'd5:  r = u(OP_QMUL, R_T1, R_ZERO, B_DZX, R_T1);
			7'd6:  r = u(OP_ADD, R_T1, R_TY, B_REG, R_T1);
			7'd7:  r = u(OP_QMUL, R_T1, R_ZERO, B_IJY, R_T1);
			7'd8:  r = u(OP_QMUL, R_WX, R_WY, B_REG, R_T2);
			7'd9:  r = u(OP_QMUL, R_T2, R_ZERO, B_DXY, R_T2);
			7'd10: r = u(OP_ADD, R_T2, R_TZ, B_REG, R_T2);
			7'd11: r = u(OP_QMUL, R_T2, R_ZERO, B_IJZ, R_T2);
			// dw
			7'd12: r = u(OP_QMUL, R_QX, R_WX, B_REG, R_T3);
			7'd13: r = u(OP_QMUL, R_QY, R_WY, B_REG, R_T4);
			7'd14: r = u(OP_ADD, R_T3, R_T4, B_REG, R_T3);
			7'd15: r = u(OP_QMUL, R_QZ, R_WZ, B_REG, R_T4);
			7'd16: r = u(OP_ADD, R_T3, R_T4, B_REG, R_T3);
			7'd17: r = u(OP_NEG, R_T3, R_ZERO, B_REG, R_T3);
			// dx
			7'd18: r = u(OP_QMUL, R_QY, R_WZ, B_REG, R_T4);
			7'd19: r = u(OP_QMUL, R_QZ, R_WY, B_REG, R_T5);
			7'd20: r = u(OP_SUB, R_T4, R_T5, B_REG, R_T4);
			7'd21: r = u(OP_QMUL, R_QW, R_WX, B_REG, R_T5);
			7'd22: r = u(OP_ADD, R_T5, R_T4, B_REG, R_T4);
			// dy
			7'd23: r = u(OP_QMUL, R_QZ, R_WX, B_REG, R_T5);
			7'd24: r = u(OP_QMUL, R_QX, R_WZ, B_REG, R_T6);
			7'd25: r = u(OP_SUB, R_T5, R_T6, B_REG, R_T5);
			7'd26: r = u(OP_QMUL, R_QW, R_WY, B_REG, R_T6);
			7'd27: r = u(OP_ADD, R_T6, R_T5, B_REG, R_T5);
			// dz
			7'd28: r = u(OP_QMUL, R_QX, R_WY, B_REG, R_T6);
			7'd29: r = u(OP_QMUL, R_QY, R_WX, B_REG, R_T7);
			7'd30: r = u(OP_SUB, R_T6, R_T7, B_REG, R_T6);
			7'd31: r = u(OP_QMUL, R_QW, R_WZ, B_REG, R_T7);
			7'd32: r = u(OP_ADD, R_T7, R_T6, B_REG, R_T6);
			// quaternion update
			7'd33: r = u(OP_KMUL, R_T3, R_ZERO, B_DTH, R_T3);
			7'd34: r = u(OP_ADD, R_QW, R_T3, B_REG, R_QW);
			7'd35: r = u(OP_KMUL, R_T4, R_ZERO, B_DTH, R_T4);
			7'd36: r = u(OP_ADD, R_QX, R_T4, B_REG, R_QX);
			7'd37: r = u(OP_KMUL, R_T5, R_ZERO, B_DTH, R_T5);
			7'd38: r = u(OP_ADD, R_QY, R_T5, B_REG, R_QY);
			7'd39: r = u(OP_KMUL, R_T6, R_ZERO, B_DTH, R_T6);
			7'd40: r = u(OP_ADD, R_QZ, R_T6, B_REG, R_QZ);
			// rate update
			7'd41: r = u(OP_KMUL, R_T0, R_ZERO, B_DT, R_T0);
			7'd42: r = u(OP_ADD, R_WX, R_T0, B_REG, R_WX);
			7'd43: r = u(OP_KMUL, R_T1, R_ZERO, B_DT, R_T1);
			7'd44: r = u(OP_ADD, R_WY, R_T1, B_REG, R_WY);
			7'd45: r = u(OP_KMUL, R_T2, R_ZERO, B_DT, R_T2);
			7'd46: r = u(OP_ADD, R_WZ, R_T2, B_REG, R_WZ);
			// thrust acceleration
			7'd47: r = u(OP_QMUL, R_TH, R_ZERO, B_IM, R_T7);
			7'd48: r = u(OP_NEG, R_T7, R_ZERO, B_REG, R_T7);
			7'd49: r = u(OP_QMUL, R_QW, R_QY, B_REG, R_T8);
			7'd50: r = u(OP_QMUL, R_QX, R_QZ, B_REG, R_T9);
			7'd51: r = u(OP_ADD, R_T8, R_T9, B_REG, R_T8);
			7'd52: r = u(OP_QMUL, R_T7, R_T8, B_REG, R_T8);
			7'd53: r = u(OP_DBL, R_T8, R_ZERO, B_REG, R_T8);
			7'd54: r = u(OP_QMUL, R_QY, R_QZ, B_REG, R_T9);
			7'd55: r = u(OP_QMUL, R_QW, R_QX, B_REG, R_TA);
			7'd56: r = u(OP_SUB, R_T9, R_TA, B_REG, R_T9);
			7'd57: r = u(OP_QMUL, R_T7, R_T9, B_REG, R_T9);
			7'd58: r = u(OP_DBL, R_T9, R_ZERO, B_REG, R_T9);
			7'd59: r = u(OP_QMUL, R_QX, R_QX, B_REG, R_TA);
			7'd60: r = u(OP_QMUL, R_QY, R_QY, B_REG, R_TB);
			7'd61: r = u(OP_ADD, R_TA, R_TB, B_REG, R_TA);
			7'd62: r = u(OP_QMUL, R_T7, R_TA, B_REG, R_TA);
			7'd63: r = u(OP_DBL, R_TA, R_ZERO, B_REG, R_TA);
			7'd64: r = u(OP_SUB, R_T7, R_TA, B_REG, R_TA);
			7'd65: r = u(OP_ADD, R_TA, R_GR, B_REG, R_TA);
			// position and velocity
			7'd66: r = u(OP_KMUL, R_VN, R_ZERO, B_DT, R_TB);
			7'd67: r = u(OP_ADD, R_PN, R_TB, B_REG, R_PN);
			7'd68: r = u(OP_KMUL, R_VE, R_ZERO, B_DT, R_TB);
			7'd69: r = u(OP_ADD, R_PE, R_TB, B_REG, R_PE);
			7'd70: r = u(OP_KMUL, R_VD, R_ZERO, B_DT, R_TB);
			7'd71: r = u(OP_ADD, R_PD, R_TB, B_REG, R_PD);
			7'd72: r = u(OP_KMUL, R_T8, R_ZERO, B_DT, R_T8);
			7'd73: r = u(OP_ADD, R_VN, R_T8, B_REG, R_VN);
			7'd74: r = u(OP_KMUL, R_T9, R_ZERO, B_DT, R_T9);
			7'd75: r = u(OP_ADD, R_VE, R_T9, B_REG, R_VE);
			7'd76: r = u(OP_KMUL, R_TA, R_ZERO, B_DT, R_TA);
			7'd77: r = u(OP_ADD, R_VD, R_TA, B_REG, R_VD);
			default: r = u(OP_ADD, R_ZERO, R_ZERO, B_REG, R_ZERO);
		endcase
		return r;
	endfunction

	localparam logic [PCW-1:0] LAST_PC = PCW'(NUOP - 1);

	function automatic logic signed [31:0] sat32(logic signed [67:0] x);
		if (x > 68'sd2147483647) return 32'sh7fffffff;
		if (x < -68'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage

FILE: src/rigid_body_quaternion_euler_step.sv
// ----------------------------------------------------------------------------
// rigid_body_quaternion_euler_step
// One forward-Euler step of a rigid body per input transfer.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_ready   | thrust_cmd, torque_cmd_*, disturb_*
// out     | output    | out_valid/out_ready | att_*, rate_*, pos_*, clamped
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Clamping happens at the input transfer edge. The sequencer then runs 78
// micro-steps (issue, then write-back) through the single registered multiplier
// and then raises out_valid. The result is read straight from the state
// registers, which hold still while out_valid is high; in_ready returns the
// cycle after the output transfer, so no new item is accepted until the result
// is taken, and out_ready held low delays it. Reset restores the identity
// attitude, zero rate, position and velocity, and the default register values.
// ----------------------------------------------------------------------------
`include "rigid_body_quaternion_euler_step_defines.svh"
module rigid_body_quaternion_euler_step import rbqe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] thrust_cmd,
	input  logic signed [31:0] torque_cmd_x,
	input  logic signed [31:0] torque_cmd_y,
	input  logic signed [31:0] torque_cmd_z,
	input  logic signed [31:0] disturb_x,
	input  logic signed [31:0] disturb_y,
	input  logic signed [31:0] disturb_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] att_w,
	output logic signed [31:0] att_x,
	output logic signed [31:0] att_y,
	output logic signed [31:0] att_z,
	output logic signed [31:0] rate_x,
	output logic signed [31:0] rate_y,
	output logic signed [31:0] rate_z,
	output logic signed [31:0] pos_n,
	output logic signed [31:0] pos_e,
	output logic signed [31:0] pos_d,
	output logic               clamped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	// Configuration registers.
	logic [30:0]        ijx_q, ijy_q, ijz_q, im_q, mtq_q, mth_q;
	logic signed [31:0] dyz_q, dzx_q;
	logic signed [31:0] dxy;

	// Register file: state words, temporaries, a zero and gravity slot.
	logic signed [31:0] rf_q [32];

	logic           busy_q;
	logic           clamp_q;
	logic           start;
	logic [PCW-1:0] pc;
	logic           issue, wb, done;
	uop_t           uop;
	logic signed [31:0] alu_a, alu_y;
	logic signed [33:0] alu_b;

	// Clamping of the accepted commands.
	logic signed [31:0] thr_c, tx_c, ty_c, tz_c;
	logic               hit;
	logic signed [31:0] mtq_s, mth_s;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q && !out_valid;
	assign start     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ijx_q <= 31'd936228;
			ijy_q <= 31'd819200;
			ijz_q <= 31'd546133;
			dyz_q <= -32'sd2621;
			dzx_q <= 32'sd3277;
			im_q  <= 31'd22947;
			mtq_q <= 31'd359965;
			mth_q <= 31'd3599647;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INV_JX:     ijx_q <= cfg_data[30:0];
				REG_INV_JY:     ijy_q <= cfg_data[30:0];
				REG_INV_JZ:     ijz_q <= cfg_data[30:0];
				REG_DIFF_YZ:    dyz_q <= cfg_data;
				REG_DIFF_ZX:    dzx_q <= cfg_data;
				REG_INV_MASS:   im_q  <= cfg_data[30:0];
				REG_MAX_TORQUE: mtq_q <= cfg_data[30:0];
				REG_MAX_THRUST: mth_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// The third inertia difference is the saturated negated sum of the other two.
	assign dxy = sat32(-(68'(dyz_q) + 68'(dzx_q)));

	assign mtq_s = {1'b0, mtq_q};
	assign mth_s = {1'b0, mth_q};

	always_comb begin
		hit   = 1'b0;
		thr_c = thrust_cmd;
		if (thrust_cmd < 0) begin thr_c = '0; hit = 1'b1; end
		else if (thrust_cmd > mth_s) begin thr_c = mth_s; hit = 1'b1; end
		tx_c = torque_cmd_x;
		if (torque_cmd_x < -mtq_s) begin tx_c = -mtq_s; hit = 1'b1; end
		else if (torque_cmd_x > mtq_s) begin tx_c = mtq_s; hit = 1'b1; end
		ty_c = torque_cmd_y;
		if (torque_cmd_y < -mtq_s) begin ty_c = -mtq_s; hit = 1'b1; end
		else if (torque_cmd_y > mtq_s) begin ty_c = mtq_s; hit = 1'b1; end
		tz_c = torque_cmd_z;
		if (torque_cmd_z < -mtq_s) begin tz_c = -mtq_s; hit = 1'b1; end
		else if (torque_cmd_z > mtq_s) begin tz_c = mtq_s; hit = 1'b1; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (start) busy_q <= 1'b1;
			else if (done) busy_q <= 1'b0;
			if (done) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	rbqe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pc     (pc),
		.issue  (issue),
		.wb     (wb),
		.done   (done)
	);

	assign uop   = prog(pc);
	assign alu_a = rf_q[uop.ra];

	always_comb begin
		case (uop.bs)
			B_IJX:   alu_b = 34'({1'b0, ijx_q});
			B_IJY:   alu_b = 34'({1'b0, ijy_q});
			B_IJZ:   alu_b = 34'({1'b0, ijz_q});
			B_DYZ:   alu_b = 34'(dyz_q);
			B_DZX:   alu_b = 34'(dzx_q);
			B_DXY:   alu_b = 34'(dxy);
			B_IM:    alu_b = 34'({1'b0, im_q});
			B_DT:    alu_b = DT_Q32;
			B_DTH:   alu_b = DTH_Q32;
			default: alu_b = 34'(rf_q[uop.rb]);
		endcase
	end

	rbqe_alu u_alu (
		.clk (clk),
		.op  (uop.op),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y)
	);

	// All words reset; the thrust and torque words are loaded at the start of each item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++)
				rf_q[i] <= (i == R_QW) ? ONE_Q : ((i == R_GR) ? GRAV_Q : 32'sd0);
		end else if (start) begin
			rf_q[R_TH] <= thr_c;
			rf_q[R_TX] <= sat32(68'(tx_c) + 68'(disturb_x));
			rf_q[R_TY] <= sat32(68'(ty_c) + 68'(disturb_y));
			rf_q[R_TZ] <= sat32(68'(tz_c) + 68'(disturb_z));
		end else if (wb && uop.rd != R_ZERO) begin
			rf_q[uop.rd] <= alu_y;
		end
	end

	always_ff @(posedge clk) begin
		if (start) clamp_q <= hit;
	end

	assign att_w   = rf_q[R_QW];
	assign att_x   = rf_q[R_QX];
	assign att_y   = rf_q[R_QY];
	assign att_z   = rf_q[R_QZ];
	assign rate_x  = rf_q[R_WX];
	assign rate_y  = rf_q[R_WY];
	assign rate_z  = rf_q[R_WZ];
	assign pos_n   = rf_q[R_PN];
	assign pos_e   = rf_q[R_PE];
	assign pos_d   = rf_q[R_PD];
	assign clamped = clamp_q;

	`RB_ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy_q, !in_ready, "accepted while busy")
	`RB_ASSERT_NXT(a_done_valid, clk, arst_n, done, out_valid, "result lost")
	`RB_ASSERT_IMP(a_issue_busy, clk, arst_n, issue, busy_q, "issue while idle")
endmodule

FILE: src/rbqe_alu.sv
// ----------------------------------------------------------------------------
// rbqe_alu
// Shared saturating multiply and add unit; the multiply result is registered.
// ----------------------------------------------------------------------------
module rbqe_alu import rbqe_pkg::*; (
	input  logic               clk,
	input  op_t                op,
	input  logic signed [31:0] a,
	input  logic signed [33:0] b,
	output logic signed [31:0] y
);
	logic signed [67:0] prod_s1;
	op_t                op_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	logic signed [67:0] rnd;

	always_ff @(posedge clk) begin
		prod_s1 <= 68'(a) * 68'(b);
		op_s1   <= op;
		a_s1    <= a;
		b_s1    <= b[31:0];
	end

	always_comb begin
		rnd = '0;
		y   = '0;
		case (op_s1)
			OP_QMUL: begin
				rnd = (prod_s1 + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
				y   = sat32(rnd);
			end
			OP_KMUL: begin
				rnd = (prod_s1 + (68'sd1 <<< 31)) >>> 32;
				y   = sat32(rnd);
			end
			OP_ADD: y = sat32(68'(a_s1) + 68'(b_s1));
			OP_SUB: y = sat32(68'(a_s1) - 68'(b_s1));
			OP_NEG: y = sat32(-68'(a_s1));
			OP_DBL: y = sat32(68'(a_s1) <<< 1);
			default: y = '0;
		endcase
	end
endmodule

FILE: src/rbqe_seq.sv
// ----------------------------------------------------------------------------
// rbqe_seq
// Micro-program counter: each step issues in S_ISSUE, then writes back in S_WB.
// ----------------------------------------------------------------------------
`include "rigid_body_quaternion_euler_step_defines.svh"
module rbqe_seq import rbqe_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic [PCW-1:0] pc,
	output logic           issue,
	output logic           wb,
	output logic           done
);
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ISSUE = 3'b010,
		S_WB    = 3'b100
	} state_t;

	state_t         state_q;
	logic [PCW-1:0] pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					state_q <= S_ISSUE;
					pc_q    <= '0;
				end
				S_ISSUE: state_q <= S_WB;
				S_WB: begin
					if (pc_q == LAST_PC) state_q <= S_IDLE;
					else begin
						state_q <= S_ISSUE;
						pc_q    <= pc_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pc    = pc_q;
	assign issue = (state_q == S_ISSUE);
	assign wb    = (state_q == S_WB);
	assign done  = wb && (pc_q == LAST_PC);

	`RB_ASSERT_IMP(a_start_idle, clk, arst_n, start, state_q == S_IDLE, "start while busy")
	`RB_ASSERT_NXT(a_issue_wb, clk, arst_n, issue, wb, "issue not followed by write-back")
	`RB_ASSERT_IMP(a_pc_range, clk, arst_n, state_q != S_IDLE, pc_q <= LAST_PC, "pc overrun")
endmodule
